### src/qbid_pkg.sv
// Shared widths, constants and detector phase type for the QRS beat interval detector.
package qbid_pkg;

  localparam int SAMPLE_W   = 10;
  localparam int LP_W       = 18;
  localparam int HP_W       = 24;
  localparam int DER_W      = 27;
  localparam int SCALED_W   = 35;
  localparam int MAG_W      = 32;
  localparam int SQ_W       = 40;
  localparam int LEVEL_W    = 44;
  localparam int COUNT_W    = 16;
  localparam int THR_W      = 48;
  localparam int RAW_DEPTH  = 12;
  localparam int LP_DEPTH   = 32;
  localparam int HP_DEPTH   = 4;
  localparam int WINDOW_DEF = 32;
  localparam int LEVEL_SHIFT = 4;

  localparam logic [THR_W-1:0]   THR_RESET = 48'd2000000;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic [SQ_W-1:0]    SQ_MAX    = '1;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_ABOVE = 2'd1,
    PH_BELOW = 2'd2
  } phase_t;

endpackage

### src/qbid_filter.sv
// Input register plus recursive lowpass and highpass filter stage.
module qbid_filter
  import qbid_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   up_valid,
  output logic                   up_ready,
  input  logic [SAMPLE_W-1:0]    up_sample,
  output logic                   down_valid,
  input  logic                   down_ready,
  output logic signed [HP_W-1:0] down_hp
);

  logic [SAMPLE_W-1:0]    x_r;
  logic                   a_v_r;
  logic signed [HP_W-1:0] hp_r;
  logic                   b_v_r;
  logic [SAMPLE_W-1:0]    raw_r [RAW_DEPTH];
  logic [LP_W-1:0]        lp_r  [LP_DEPTH];

  logic            rdy_a;
  logic            rdy_b;
  logic            load_a;
  logic            load_b;
  logic [LP_W-1:0] lp_nxt;
  logic [HP_W-1:0] hp_nxt;

  assign rdy_b    = !b_v_r || down_ready;
  assign rdy_a    = !a_v_r || rdy_b;
  assign load_a   = up_valid && rdy_a;
  assign load_b   = a_v_r && rdy_b;
  assign up_ready = rdy_a;

  assign down_valid = b_v_r;
  assign down_hp    = hp_r;

  always_comb begin
    lp_nxt = {lp_r[0][LP_W-2:0], 1'b0} - lp_r[1] + LP_W'(x_r)
           - LP_W'({raw_r[5], 1'b0}) + LP_W'(raw_r[11]);
    hp_nxt = HP_W'(0) - HP_W'(hp_r) - HP_W'($signed(lp_nxt))
           + {lp_r[15][LP_W-1], lp_r[15], 5'b0} + HP_W'($signed(lp_r[LP_DEPTH-1]));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
      hp_r  <= '0;
      for (int i = 0; i < RAW_DEPTH; i++) raw_r[i] <= '0;
      for (int i = 0; i < LP_DEPTH; i++) lp_r[i] <= '0;
    end else begin
      if (rdy_a) a_v_r <= up_valid;
      if (rdy_b) b_v_r <= a_v_r;
      if (load_b) begin
        hp_r     <= $signed(hp_nxt);
        raw_r[0] <= x_r;
        for (int i = 1; i < RAW_DEPTH; i++) raw_r[i] <= raw_r[i-1];
        lp_r[0] <= lp_nxt;
        for (int i = 1; i < LP_DEPTH; i++) lp_r[i] <= lp_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_a) x_r <= up_sample;
  end

endmodule

### src/qbid_energy.sv
// Derivative, squaring and moving window integration stages.
module qbid_energy
  import qbid_pkg::*;
#(
  parameter int WINDOW_LEN = WINDOW_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   up_valid,
  output logic                   up_ready,
  input  logic signed [HP_W-1:0] up_hp,
  output logic                   down_valid,
  input  logic                   down_ready,
  output logic [LEVEL_W-1:0]     down_level
);

  localparam int SUM_W = SQ_W + $clog2(WINDOW_LEN);

  logic signed [HP_W-1:0] hist_r [HP_DEPTH];
  logic [MAG_W-1:0]       mag_r;
  logic                   c_v_r;
  logic [SQ_W-1:0]        sq_r;
  logic                   d_v_r;
  logic [SQ_W-1:0]        win_r [WINDOW_LEN];
  logic [SUM_W-1:0]       sum_r;
  logic [LEVEL_W-1:0]     lvl_r;
  logic                   e_v_r;

  logic rdy_c, rdy_d, rdy_e;
  logic load_c, load_d, load_e;
  logic signed [DER_W-1:0]    der;
  logic signed [SCALED_W-1:0] der_ext;
  logic signed [SCALED_W-1:0] scaled;
  logic [MAG_W-1:0]           shifted;
  logic [MAG_W-1:0]           mag_nxt;
  logic [2*MAG_W-1:0]         prod;
  logic [SQ_W-1:0]            sq_nxt;
  logic [SUM_W-1:0]           sum_nxt;

  assign rdy_e  = !e_v_r || down_ready;
  assign rdy_d  = !d_v_r || rdy_e;
  assign rdy_c  = !c_v_r || rdy_d;
  assign load_c = up_valid && rdy_c;
  assign load_d = c_v_r && rdy_d;
  assign load_e = d_v_r && rdy_e;
  assign up_ready   = rdy_c;
  assign down_valid = e_v_r;
  assign down_level = lvl_r;

  always_comb begin
    der = DER_W'(up_hp) + (DER_W'(hist_r[0]) <<< 1)
        - (DER_W'(hist_r[2]) <<< 1) - DER_W'(hist_r[3]);
    der_ext = SCALED_W'(der);
    scaled  = (der_ext <<< 7) + (der_ext <<< 6) + (der_ext <<< 3);
    shifted = scaled[SCALED_W-1:3];
    mag_nxt = shifted[MAG_W-1] ? (~shifted + MAG_W'(1)) : shifted;
    prod    = mag_r * mag_r;
    sq_nxt  = (|prod[2*MAG_W-1:SQ_W]) ? SQ_MAX : prod[SQ_W-1:0];
    sum_nxt = sum_r - SUM_W'(win_r[WINDOW_LEN-1]) + SUM_W'(sq_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_v_r <= 1'b0;
      d_v_r <= 1'b0;
      e_v_r <= 1'b0;
      sum_r <= '0;
      for (int i = 0; i < HP_DEPTH; i++) hist_r[i] <= '0;
      for (int i = 0; i < WINDOW_LEN; i++) win_r[i] <= '0;
    end else begin
      if (rdy_c) c_v_r <= up_valid;
      if (rdy_d) d_v_r <= c_v_r;
      if (rdy_e) e_v_r <= d_v_r;
      if (load_c) begin
        hist_r[0] <= up_hp;
        for (int i = 1; i < HP_DEPTH; i++) hist_r[i] <= hist_r[i-1];
      end
      if (load_e) begin
        sum_r    <= sum_nxt;
        win_r[0] <= sq_r;
        for (int i = 1; i < WINDOW_LEN; i++) win_r[i] <= win_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_c) mag_r <= mag_nxt;
    if (load_d) sq_r  <= sq_nxt;
    if (load_e) lvl_r <= LEVEL_W'(sum_nxt >> LEVEL_SHIFT);
  end

endmodule

### src/qbid_detect.sv
// Three-phase threshold detector, interval counter and output register.
module qbid_detect
  import qbid_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic [THR_W-1:0]   threshold,
  input  logic               up_valid,
  output logic               up_ready,
  input  logic [LEVEL_W-1:0] up_level,
  output logic               down_valid,
  input  logic               down_ready,
  output logic [LEVEL_W-1:0] down_level,
  output logic [COUNT_W-1:0] down_interval,
  output logic               down_new,
  output logic [1:0]         down_phase
);

  phase_t             phase_r, phase_nxt;
  logic [COUNT_W-1:0] count_r, count_nxt;
  logic [COUNT_W-1:0] last_r, last_nxt;
  logic               new_nxt;
  logic               o_v_r;
  logic [LEVEL_W-1:0] lvl_r;
  logic               new_r;

  logic               rdy;
  logic               load;
  logic               above;
  logic               below;
  logic [COUNT_W-1:0] count_inc;

  assign rdy      = !o_v_r || down_ready;
  assign load     = up_valid && rdy;
  assign up_ready = rdy;
  assign above    = THR_W'(up_level) > threshold;
  assign below    = THR_W'(up_level) < threshold;

  assign down_valid    = o_v_r;
  assign down_level    = lvl_r;
  assign down_interval = last_r;
  assign down_new      = new_r;
  assign down_phase    = phase_r;

  always_comb begin
    count_inc = (count_r < COUNT_MAX) ? count_r + COUNT_W'(1) : count_r;
    phase_nxt = phase_r;
    count_nxt = count_r;
    last_nxt  = last_r;
    new_nxt   = 1'b0;
    case (phase_r)
      PH_IDLE: begin
        if (above) begin
          phase_nxt = PH_ABOVE;
          count_nxt = '0;
        end
      end
      PH_ABOVE: begin
        count_nxt = count_inc;
        if (below) phase_nxt = PH_BELOW;
      end
      PH_BELOW: begin
        count_nxt = count_inc;
        if (above) begin
          phase_nxt = PH_IDLE;
          last_nxt  = count_inc;
          new_nxt   = 1'b1;
        end
      end
      default: begin
        phase_nxt = phase_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      count_r <= '0;
      last_r  <= '0;
      o_v_r   <= 1'b0;
    end else begin
      if (rdy) o_v_r <= up_valid;
      if (load) begin
        phase_r <= phase_nxt;
        count_r <= count_nxt;
        last_r  <= last_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      lvl_r <= up_level;
      new_r <= new_nxt;
    end
  end

endmodule

### src/qrs_beat_interval_detector.sv
// Top level of the QRS beat interval detector.
// One ECG sample enters per in_ beat and one result leaves per out_ beat,
// in order, one result for every sample.
// in_tdata[9:0] carries the unsigned 10-bit converter sample.
// out_tdata carries the integrated energy level, the last measured beat
// interval in samples, a flag for a new interval on this sample, and the
// detector phase (0 idle, 1 above after start, 2 dropped below).
// cfg_wr_en with cfg_wr_data loads the 48-bit beat threshold; write it only
// while no samples are in flight.
// Throughput: one sample per cycle while the receiver accepts results, through
// the six-register pipeline (input, filter, derivative, square, window sum, output).
// Each stage loads when it is empty or its successor moves, so a stalled
// receiver holds the output register while samples keep entering until the
// empty stages fill up; nothing is dropped.
// Reset clears the filter and window histories, the window sum, the
// detector phase and counters, and sets the threshold to 2000000.
module qrs_beat_interval_detector
  import qbid_pkg::*;
#(
  parameter int WINDOW_LEN = WINDOW_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [15:0]      in_tdata,    // [9:0] ecg_sample
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [63:0]      out_tdata,   // [43:0] integrated_level, [59:44] interval_samples,
                                        // [60] interval_valid, [62:61] detector_phase
  input  logic             cfg_wr_en,
  input  logic [THR_W-1:0] cfg_wr_data
);

  logic [THR_W-1:0]   thr_r;
  logic               flt_valid, flt_ready;
  logic signed [HP_W-1:0] flt_hp;
  logic               eng_valid, eng_ready;
  logic [LEVEL_W-1:0] eng_level;
  logic [LEVEL_W-1:0] det_level;
  logic [COUNT_W-1:0] det_interval;
  logic               det_new;
  logic [1:0]         det_phase;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_RESET;
    end else if (cfg_wr_en) begin
      thr_r <= cfg_wr_data;
    end
  end

  qbid_filter u_filter (
    .clk        (clk),
    .rst_n      (rst_n),
    .up_valid   (in_tvalid),
    .up_ready   (in_tready),
    .up_sample  (in_tdata[SAMPLE_W-1:0]),
    .down_valid (flt_valid),
    .down_ready (flt_ready),
    .down_hp    (flt_hp)
  );

  qbid_energy #(
    .WINDOW_LEN (WINDOW_LEN)
  ) u_energy (
    .clk        (clk),
    .rst_n      (rst_n),
    .up_valid   (flt_valid),
    .up_ready   (flt_ready),
    .up_hp      (flt_hp),
    .down_valid (eng_valid),
    .down_ready (eng_ready),
    .down_level (eng_level)
  );

  qbid_detect u_detect (
    .clk           (clk),
    .rst_n         (rst_n),
    .threshold     (thr_r),
    .up_valid      (eng_valid),
    .up_ready      (eng_ready),
    .up_level      (eng_level),
    .down_valid    (out_tvalid),
    .down_ready    (out_tready),
    .down_level    (det_level),
    .down_interval (det_interval),
    .down_new      (det_new),
    .down_phase    (det_phase)
  );

  assign out_tdata = {1'b0, det_phase, det_new, det_interval, det_level};

endmodule
